>>> rtl/core/pvh_pkg.sv
package pvh_pkg;

  // Linearization table geometry.
  localparam int TABLE_ENTRIES = 11;
  localparam int LIN_IDX_W = $clog2(TABLE_ENTRIES);
  localparam int LIN_X_W = 16 + LIN_IDX_W;
  localparam logic [LIN_IDX_W-1:0] LIN_TOP = LIN_IDX_W'(TABLE_ENTRIES - 1);

  // Field widths.
  localparam int PHASE_W = 4;
  localparam int FLOW_W = 18;
  localparam int TIME_W = 32;
  localparam int ARG_W = 32;
  localparam int REG_W = 16;
  localparam int REG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_HOMING_AMP   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RUN_AMP      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HOME_SPEED   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HOMING_ACCEL = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RUN_SPEED    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RUN_ACCEL    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_STOP_WAIT    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_WAIT  = 3'd7;

  // Driver commands.
  typedef enum logic [2:0] {
    CMD_AMP     = 3'd0,
    CMD_SPEED   = 3'd1,
    CMD_ACCEL   = 3'd2,
    CMD_MOVE    = 3'd3,
    CMD_GOTO    = 3'd4,
    CMD_CLEAR   = 3'd5,
    CMD_DISABLE = 3'd6
  } cmd_t;

  // Source of the argument of a result.
  typedef enum logic [3:0] {
    ARG_HOMING_AMP,
    ARG_RUN_AMP,
    ARG_HOME_SPEED,
    ARG_HOMING_ACCEL,
    ARG_RUN_SPEED,
    ARG_RUN_ACCEL,
    ARG_MOVE_STOP,
    ARG_MOVE_OFFSET,
    ARG_ZERO,
    ARG_GOTO
  } arg_sel_t;

  // Move distances in Q16.16 degrees.
  localparam logic [ARG_W-1:0] MOVE_STOP_Q16   = 32'hFFA6_0000;
  localparam logic [ARG_W-1:0] MOVE_OFFSET_Q16 = 32'h001E_0000;

  // Controller to datapath commands.
  typedef struct packed {
    logic                 capture;
    logic                 cap_start;
    logic                 load;
    cmd_t                 cmd;
    arg_sel_t             sel;
    logic                 last;
    logic [PHASE_W-1:0]   phase;
  } ctl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic opcode;
    logic motor_present;
    logic accept_first;
    logic accept_second;
    logic stop_done;
    logic offset_done;
    logic out_free;
  } dp_sts_t;

  // Q0.16 linearization points, equally spaced over the request range.
  function automatic logic [15:0] lin_point(input logic [LIN_IDX_W-1:0] idx);
    logic [15:0] val;
    case (idx)
      4'd0:    val = 16'd0;
      4'd1:    val = 16'd8192;
      4'd2:    val = 16'd10551;
      4'd3:    val = 16'd12911;
      4'd4:    val = 16'd15204;
      4'd5:    val = 16'd17760;
      4'd6:    val = 16'd20316;
      4'd7:    val = 16'd23462;
      4'd8:    val = 16'd27853;
      4'd9:    val = 16'd35521;
      4'd10:   val = 16'd58982;
      default: val = 16'd0;
    endcase
    return val;
  endfunction

  // Whole number to Q16.16, saturating where it does not fit.
  function automatic logic [ARG_W-1:0] q16_int(input logic [REG_W-1:0] v);
    logic [ARG_W-1:0] res;
    if (v[REG_W-1]) begin
      res = 32'h7FFF_FFFF;
    end else begin
      res = {v, 16'h0000};
    end
    return res;
  endfunction

endpackage

>>> rtl/core/pinch_valve_homing_and_position_core.sv
// A homing step loads its results into the output stage after the decision state; a
// position command first passes the three-stage interpolation and scaling pipeline.
// A beat gives no result, one or two homing results, or one position command result. A new
// input beat is taken only once all results of the last one are loaded; output stalls delay this.
// Reset (rst, synchronous): phase returns to disabled, move start time to zero,
// configuration registers to their defaults; the output stage empties.
module pinch_valve_homing_and_position_core (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pvh_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [pvh_pkg::REG_W-1:0]     cfg_data,
  // Input stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [17:0] flow_request, [49:18] now_ms, [50] motor_present,
  // [51] accept_first, [52] accept_second, [55:53] zero
  input  logic [55:0]                   s_axis_tdata,
  // [0] opcode
  input  logic [0:0]                    s_axis_tuser,
  // Output stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] argument, [35:32] phase_after, [39:36] zero
  output logic [39:0]                   m_axis_tdata,
  // [2:0] command
  output logic [2:0]                    m_axis_tuser,
  output logic                          m_axis_tlast
);
  import pvh_pkg::*;

  ctl_cmd_t           ctl;
  dp_sts_t            sts;
  cmd_t               out_cmd;
  logic [ARG_W-1:0]   out_arg;
  logic [PHASE_W-1:0] out_phase;

  // Registers may be written at any time outside reset.
  assign cfg_ready = !rst;

  pvh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  pvh_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_opcode (s_axis_tuser[0]),
    .in_flow   (s_axis_tdata[17:0]),
    .in_now    (s_axis_tdata[49:18]),
    .in_motor  (s_axis_tdata[50]),
    .in_acc1   (s_axis_tdata[51]),
    .in_acc2   (s_axis_tdata[52]),
    .ctl       (ctl),
    .sts       (sts),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_cmd   (out_cmd),
    .out_arg   (out_arg),
    .out_phase (out_phase),
    .out_last  (m_axis_tlast)
  );

  // Pack the result beat.
  assign m_axis_tdata = {4'h0, out_phase, out_arg};
  assign m_axis_tuser = out_cmd;

endmodule

>>> rtl/core/pvh_ctrl.sv
module pvh_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pvh_pkg::dp_sts_t    sts,
  output pvh_pkg::ctl_cmd_t   ctl
);
  import pvh_pkg::*;

  // Homing phases.
  localparam logic [PHASE_W-1:0] PH_DISABLED    = 4'd0;
  localparam logic [PHASE_W-1:0] PH_LOWER_AMP   = 4'd1;
  localparam logic [PHASE_W-1:0] PH_HOME_SPEED  = 4'd2;
  localparam logic [PHASE_W-1:0] PH_MOVE_STOP   = 4'd3;
  localparam logic [PHASE_W-1:0] PH_WAIT_STOP   = 4'd4;
  localparam logic [PHASE_W-1:0] PH_RUN_AMP     = 4'd5;
  localparam logic [PHASE_W-1:0] PH_MOVE_OFFSET = 4'd6;
  localparam logic [PHASE_W-1:0] PH_WAIT_OFFSET = 4'd7;
  localparam logic [PHASE_W-1:0] PH_ZERO_POS    = 4'd8;
  localparam logic [PHASE_W-1:0] PH_RUN_SPEED   = 4'd9;
  localparam logic [PHASE_W-1:0] PH_HOMED       = 4'd10;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_LIN1,
    S_LIN2,
    S_OUT1,
    S_OUT2
  } state_t;

  state_t              state;
  logic [PHASE_W-1:0]  phase;
  logic                two;
  cmd_t                cmd1;
  cmd_t                cmd2;
  arg_sel_t            sel1;
  arg_sel_t            sel2;

  // Decision for the item held in the datapath.
  logic [PHASE_W-1:0]  ph_eff;
  logic [PHASE_W-1:0]  phase_next;
  logic [1:0]          count_next;
  cmd_t                cmd1_next;
  cmd_t                cmd2_next;
  arg_sel_t            sel1_next;
  arg_sel_t            sel2_next;
  logic                start_next;

  assign ph_eff = (phase == PH_DISABLED) ? PH_LOWER_AMP : phase;

  always_comb begin
    phase_next = phase;
    count_next = 2'd0;
    cmd1_next  = CMD_AMP;
    cmd2_next  = CMD_ACCEL;
    sel1_next  = ARG_ZERO;
    sel2_next  = ARG_ZERO;
    start_next = 1'b0;
    if (sts.opcode) begin
      phase_next = PH_DISABLED;
      count_next = 2'd1;
      cmd1_next  = CMD_DISABLE;
    end else if (phase != PH_HOMED) begin
      phase_next = ph_eff;
      case (ph_eff)
        PH_LOWER_AMP: begin
          count_next = 2'd1;
          cmd1_next  = CMD_AMP;
          sel1_next  = ARG_HOMING_AMP;
          if (sts.accept_first) phase_next = PH_HOME_SPEED;
        end
        PH_HOME_SPEED: begin
          count_next = 2'd1;
          cmd1_next  = CMD_SPEED;
          sel1_next  = ARG_HOME_SPEED;
          sel2_next  = ARG_HOMING_ACCEL;
          if (sts.accept_first) begin
            count_next = 2'd2;
            if (sts.accept_second) phase_next = PH_MOVE_STOP;
          end
        end
        PH_MOVE_STOP: begin
          count_next = 2'd1;
          start_next = 1'b1;
          cmd1_next  = CMD_MOVE;
          sel1_next  = ARG_MOVE_STOP;
          if (sts.accept_first) phase_next = PH_WAIT_STOP;
        end
        PH_WAIT_STOP: begin
          if (sts.stop_done) phase_next = PH_RUN_AMP;
        end
        PH_RUN_AMP: begin
          count_next = 2'd1;
          cmd1_next  = CMD_AMP;
          sel1_next  = ARG_RUN_AMP;
          if (sts.accept_first) phase_next = PH_MOVE_OFFSET;
        end
        PH_MOVE_OFFSET: begin
          count_next = 2'd1;
          start_next = 1'b1;
          cmd1_next  = CMD_MOVE;
          sel1_next  = ARG_MOVE_OFFSET;
          if (sts.accept_first) phase_next = PH_WAIT_OFFSET;
        end
        PH_WAIT_OFFSET: begin
          if (sts.offset_done) phase_next = PH_ZERO_POS;
        end
        PH_ZERO_POS: begin
          count_next = 2'd1;
          cmd1_next  = CMD_CLEAR;
          sel1_next  = ARG_ZERO;
          if (sts.accept_first) phase_next = PH_RUN_SPEED;
        end
        PH_RUN_SPEED: begin
          count_next = 2'd1;
          cmd1_next  = CMD_SPEED;
          sel1_next  = ARG_RUN_SPEED;
          sel2_next  = ARG_RUN_ACCEL;
          if (sts.accept_first) begin
            count_next = 2'd2;
            if (sts.accept_second) phase_next = PH_HOMED;
          end
        end
        default: begin
          // Unreachable phase codes leave everything as it is.
          count_next = 2'd0;
        end
      endcase
    end else begin
      count_next = 2'd1;
      cmd1_next  = CMD_GOTO;
      sel1_next  = ARG_GOTO;
    end
  end

  // Handshake and commands to the datapath; nothing is taken during reset.
  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    ctl.capture   = in_valid && in_ready;
    ctl.cap_start = (state == S_DECIDE) && sts.motor_present && start_next;
    ctl.load      = 1'b0;
    ctl.cmd       = cmd1;
    ctl.sel       = sel1;
    ctl.last      = !two;
    ctl.phase     = phase;
    if (state == S_OUT1) begin
      ctl.load = sts.out_free;
    end else if (state == S_OUT2) begin
      ctl.load = sts.out_free;
      ctl.cmd  = cmd2;
      ctl.sel  = sel2;
      ctl.last = 1'b1;
    end
  end

  // Sequencer state, homing phase and the pending results of the item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_DISABLED;
      two   <= 1'b0;
      cmd1  <= CMD_AMP;
      cmd2  <= CMD_ACCEL;
      sel1  <= ARG_ZERO;
      sel2  <= ARG_ZERO;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (!sts.motor_present) begin
            state <= S_IDLE;
          end else begin
            phase <= phase_next;
            two   <= (count_next == 2'd2);
            cmd1  <= cmd1_next;
            cmd2  <= cmd2_next;
            sel1  <= sel1_next;
            sel2  <= sel2_next;
            if (count_next == 2'd0) begin
              state <= S_IDLE;
            end else if (sel1_next == ARG_GOTO) begin
              state <= S_LIN1;
            end else begin
              state <= S_OUT1;
            end
          end
        end
        S_LIN1: state <= S_LIN2;
        S_LIN2: state <= S_OUT1;
        S_OUT1: begin
          if (sts.out_free) state <= two ? S_OUT2 : S_IDLE;
        end
        S_OUT2: begin
          if (sts.out_free) state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> sts.out_free) else $error("result loaded into a busy output stage");
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= PH_HOMED) else $error("homing phase out of range");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (ctl.load && ctl.last) |=> (state == S_IDLE)) else $error("no return to idle after last");
  a_first_more: assert property (@(posedge clk) disable iff (rst)
    (ctl.load && !ctl.last) |=> (state == S_OUT2)) else $error("second result not pending");
  a_disable_phase: assert property (@(posedge clk) disable iff (rst)
    (ctl.load && ctl.cmd == CMD_DISABLE) |-> (ctl.phase == PH_DISABLED))
    else $error("disable without disabled phase");
`endif

endmodule

>>> rtl/core/pvh_dp.sv
module pvh_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [pvh_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [pvh_pkg::REG_W-1:0]     cfg_data,
  input  logic                          in_opcode,
  input  logic [pvh_pkg::FLOW_W-1:0]    in_flow,
  input  logic [pvh_pkg::TIME_W-1:0]    in_now,
  input  logic                          in_motor,
  input  logic                          in_acc1,
  input  logic                          in_acc2,
  input  pvh_pkg::ctl_cmd_t             ctl,
  output pvh_pkg::dp_sts_t              sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output pvh_pkg::cmd_t                 out_cmd,
  output logic [pvh_pkg::ARG_W-1:0]     out_arg,
  output logic [pvh_pkg::PHASE_W-1:0]   out_phase,
  output logic                          out_last
);
  import pvh_pkg::*;

  // Configuration registers.
  logic [REG_W-1:0] homing_amp;
  logic [REG_W-1:0] run_amp;
  logic [REG_W-1:0] home_speed;
  logic [REG_W-1:0] homing_accel;
  logic [REG_W-1:0] run_speed;
  logic [REG_W-1:0] run_accel;
  logic [REG_W-1:0] stop_wait;
  logic [REG_W-1:0] offset_wait;

  always_ff @(posedge clk) begin
    if (rst) begin
      homing_amp   <= 16'd6554;
      run_amp      <= 16'd16384;
      home_speed   <= 16'd60;
      homing_accel <= 16'd600;
      run_speed    <= 16'd2000;
      run_accel    <= 16'd40000;
      stop_wait    <= 16'd3000;
      offset_wait  <= 16'd2000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HOMING_AMP:   homing_amp   <= cfg_data;
        REG_RUN_AMP:      run_amp      <= cfg_data;
        REG_HOME_SPEED:   home_speed   <= cfg_data;
        REG_HOMING_ACCEL: homing_accel <= cfg_data;
        REG_RUN_SPEED:    run_speed    <= cfg_data;
        REG_RUN_ACCEL:    run_accel    <= cfg_data;
        REG_STOP_WAIT:    stop_wait    <= cfg_data;
        REG_OFFSET_WAIT:  offset_wait  <= cfg_data;
      endcase
    end
  end

  // Held input beat.
  logic               item_opcode;
  logic [FLOW_W-1:0]  item_flow;
  logic [TIME_W-1:0]  item_now;
  logic               item_motor;
  logic               item_acc1;
  logic               item_acc2;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item_opcode <= in_opcode;
      item_flow   <= in_flow;
      item_now    <= in_now;
      item_motor  <= in_motor;
      item_acc1   <= in_acc1;
      item_acc2   <= in_acc2;
    end
  end

  // Start time of the last homing move.
  logic [TIME_W-1:0] move_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_start <= '0;
    end else if (ctl.cap_start) begin
      move_start <= item_now;
    end
  end

  // Elapsed time since the move started, wrapping modulo 2^32.
  logic [TIME_W-1:0] elapsed;
  assign elapsed = item_now - move_start;

  // Linearization, stage one: clamp, scale, segment lookup.
  logic [16:0]            flow_clamp;
  logic [LIN_X_W-1:0]     lin_x;
  logic [LIN_IDX_W-1:0]   seg;
  logic                   seg_top;
  logic [15:0]            pt_lo;
  logic [15:0]            pt_hi;
  logic [15:0]            s1_a;
  logic signed [16:0]     s1_diff;
  logic [15:0]            s1_f;

  always_comb begin
    if (item_flow[FLOW_W-1]) begin
      flow_clamp = '0;
    end else if (item_flow[16:0] > 17'd65536) begin
      flow_clamp = 17'd65536;
    end else begin
      flow_clamp = item_flow[16:0];
    end
  end

  assign lin_x   = LIN_X_W'(flow_clamp * LIN_X_W'(TABLE_ENTRIES - 1));
  assign seg     = lin_x[LIN_X_W-1:16];
  assign seg_top = (seg >= LIN_TOP);
  assign pt_lo   = lin_point(seg_top ? LIN_TOP : seg);
  assign pt_hi   = lin_point(seg_top ? LIN_TOP : seg + LIN_IDX_W'(1));

  always_ff @(posedge clk) begin
    s1_a    <= pt_lo;
    s1_diff <= seg_top ? 17'sd0 : ($signed({1'b0, pt_hi}) - $signed({1'b0, pt_lo}));
    s1_f    <= lin_x[15:0];
  end

  // Stage two: interpolate in Q0.32 and clamp.
  logic signed [33:0] s2_prod;
  logic signed [34:0] s2_sum;
  logic [31:0]        s2_lin;

  assign s2_prod = $signed({1'b0, s1_f}) * s1_diff;
  assign s2_sum  = $signed({3'b000, s1_a, 16'h0000}) + 35'(s2_prod);

  always_ff @(posedge clk) begin
    if (s2_sum < 0) begin
      s2_lin <= '0;
    end else if (s2_sum > 35'sh0_FFFF_FFFF) begin
      s2_lin <= 32'hFFFF_FFFF;
    end else begin
      s2_lin <= s2_sum[31:0];
    end
  end

  // Stage three: 45 degrees times the complement, rounded half up.
  logic [32:0]      s3_rem;
  logic [38:0]      s3_num;
  logic [ARG_W-1:0] goto_arg;

  assign s3_rem = 33'h1_0000_0000 - {1'b0, s2_lin};
  assign s3_num = 39'(s3_rem * 39'd45) + 39'd32768;

  always_ff @(posedge clk) begin
    goto_arg <= {9'd0, s3_num[38:16]};
  end

  // Argument of the result being loaded.
  logic [ARG_W-1:0] arg_mux;

  always_comb begin
    case (ctl.sel)
      ARG_HOMING_AMP:   arg_mux = {16'h0000, homing_amp};
      ARG_RUN_AMP:      arg_mux = {16'h0000, run_amp};
      ARG_HOME_SPEED:   arg_mux = q16_int(home_speed);
      ARG_HOMING_ACCEL: arg_mux = q16_int(homing_accel);
      ARG_RUN_SPEED:    arg_mux = q16_int(run_speed);
      ARG_RUN_ACCEL:    arg_mux = q16_int(run_accel);
      ARG_MOVE_STOP:    arg_mux = MOVE_STOP_Q16;
      ARG_MOVE_OFFSET:  arg_mux = MOVE_OFFSET_Q16;
      ARG_GOTO:         arg_mux = goto_arg;
      default:          arg_mux = '0;
    endcase
  end

  // Output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      out_cmd   <= ctl.cmd;
      out_arg   <= arg_mux;
      out_phase <= ctl.phase;
      out_last  <= ctl.last;
    end
  end

  // Status to the controller.
  always_comb begin
    sts.opcode        = item_opcode;
    sts.motor_present = item_motor;
    sts.accept_first  = item_acc1;
    sts.accept_second = item_acc2;
    sts.stop_done     = (elapsed >= {16'h0000, stop_wait});
    sts.offset_done   = (elapsed >= {16'h0000, offset_wait});
    sts.out_free      = !out_valid || out_ready;
  end

endmodule
